FILE: hw/rtl/ccrc_pkg.sv
// shared types, register indexes and bit helpers for the crc engine
// no dependencies

package ccrc_pkg;

	localparam int unsigned CrcMaxBits = 32;
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned CfgIdxBits = 3;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_WIDTH_SELECT   = 3'd0,
		REG_POLYNOMIAL     = 3'd1,
		REG_INIT_VALUE     = 3'd2,
		REG_FINAL_XOR      = 3'd3,
		REG_REFLECT_INPUT  = 3'd4,
		REG_REFLECT_OUTPUT = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WSEL_8  = 2'd0,
		WSEL_16 = 2'd1,
		WSEL_32 = 2'd2,
		WSEL_32_ALT = 2'd3
	} width_sel_t;

	typedef struct packed {
		logic [1:0]            width_select;
		logic [CrcMaxBits-1:0] polynomial;
		logic [CrcMaxBits-1:0] init_value;
		logic [CrcMaxBits-1:0] final_xor;
		logic                  reflect_output;
	} back_cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       last;
	} item_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [CrcMaxBits-1:0] rev32(input logic [CrcMaxBits-1:0] v);
		logic [CrcMaxBits-1:0] r;
		for (int i = 0; i < CrcMaxBits; i++) begin
			r[i] = v[CrcMaxBits-1-i];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/ccrc_front.sv
// front end: accepts byte transactions, reflects the byte when reflect_input is set, queues them
// depends on ccrc_pkg

module ccrc_front import ccrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       has_data,
	input  logic       last_byte,
	input  logic       reflect_input,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	localparam int unsigned PtrBits = $clog2(QueueDepth);
	localparam int unsigned CntBits = $clog2(QueueDepth + 1);

	item_t               entry_q [QueueDepth];
	logic [PtrBits-1:0]  wr_ptr_q;
	logic [PtrBits-1:0]  rd_ptr_q;
	logic [CntBits-1:0]  count_q;
	logic                push;
	logic                pop;
	item_t               new_item;

	assign in_stall = (count_q == CntBits'(QueueDepth));
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];

	always_comb begin
		new_item.data     = reflect_input ? rev8(data_byte) : data_byte;
		new_item.has_data = has_data;
		new_item.last     = last_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/ccrc_back.sv
// back end: eight-step crc update per byte, finalization and output register
// depends on ccrc_pkg

module ccrc_back import ccrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  back_cfg_t             cfg,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CrcMaxBits-1:0] crc_value
);

	logic [CrcMaxBits-1:0] crc_q;
	logic                  msg_start_q;
	logic                  out_valid_q;
	logic [CrcMaxBits-1:0] crc_out_q;

	logic [CrcMaxBits-1:0] mask;
	logic [CrcMaxBits-1:0] data_aligned;
	logic [CrcMaxBits-1:0] crc_next;
	logic [CrcMaxBits-1:0] crc_rev;
	logic [CrcMaxBits-1:0] result;
	logic                  top_bit;

	assign q_pop     = q_valid && (!q_item.last || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign crc_value = crc_out_q;

	always_comb begin
		unique case (width_sel_t'(cfg.width_select))
			WSEL_8: begin
				mask         = 32'h0000_00ff;
				data_aligned = {24'd0, q_item.data};
			end
			WSEL_16: begin
				mask         = 32'h0000_ffff;
				data_aligned = {16'd0, q_item.data, 8'd0};
			end
			WSEL_32, WSEL_32_ALT: begin
				mask         = 32'hffff_ffff;
				data_aligned = {q_item.data, 24'd0};
			end
			default: begin
				mask         = 32'hffff_ffff;
				data_aligned = {q_item.data, 24'd0};
			end
		endcase
	end

	always_comb begin
		crc_next = (msg_start_q ? cfg.init_value : crc_q) & mask;
		top_bit  = 1'b0;
		if (q_item.has_data) begin
			crc_next = crc_next ^ data_aligned;
			for (int i = 0; i < 8; i++) begin
				unique case (width_sel_t'(cfg.width_select))
					WSEL_8:              top_bit = crc_next[7];
					WSEL_16:             top_bit = crc_next[15];
					WSEL_32, WSEL_32_ALT: top_bit = crc_next[31];
					default:             top_bit = crc_next[31];
				endcase
				crc_next = ((crc_next << 1) ^ (top_bit ? cfg.polynomial : '0)) & mask;
			end
		end
	end

	always_comb begin
		unique case (width_sel_t'(cfg.width_select))
			WSEL_8:              crc_rev = rev32(crc_next) >> 24;
			WSEL_16:             crc_rev = rev32(crc_next) >> 16;
			WSEL_32, WSEL_32_ALT: crc_rev = rev32(crc_next);
			default:             crc_rev = rev32(crc_next);
		endcase
		result = ((cfg.reflect_output ? crc_rev : crc_next) ^ cfg.final_xor) & mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			msg_start_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				crc_q       <= crc_next;
				msg_start_q <= q_item.last;
			end
			if (q_pop && q_item.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			crc_out_q <= result;
		end
	end

endmodule

FILE: hw/rtl/configurable_crc_engine_core.sv
// configurable crc engine, 8/16/32 bit, one byte per transaction
// a closing byte is queued, then its crc is registered in crc_out_q for crc_value
// throughput: one byte per cycle unless stalled; the eight-step xor is combinational
// a held result holds back a closing byte; input stalls once the 2-entry queue fills
// reset: config registers to defaults, queue empty, crc cleared, next item loads init
// depends on ccrc_pkg, ccrc_front, ccrc_back

module configurable_crc_engine_core import ccrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CfgIdxBits-1:0] cfg_index,
	input  logic [CrcMaxBits-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  has_data,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CrcMaxBits-1:0] crc_value
);

	logic [1:0]            width_select_q;
	logic [CrcMaxBits-1:0] polynomial_q;
	logic [CrcMaxBits-1:0] init_value_q;
	logic [CrcMaxBits-1:0] final_xor_q;
	logic                  reflect_input_q;
	logic                  reflect_output_q;

	back_cfg_t back_cfg;
	logic      q_valid;
	item_t     q_item;
	logic      q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_select_q   <= 2'd0;
			polynomial_q     <= 32'd7;
			init_value_q     <= '0;
			final_xor_q      <= '0;
			reflect_input_q  <= 1'b0;
			reflect_output_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH_SELECT:   width_select_q   <= cfg_data[1:0];
				REG_POLYNOMIAL:     polynomial_q     <= cfg_data;
				REG_INIT_VALUE:     init_value_q     <= cfg_data;
				REG_FINAL_XOR:      final_xor_q      <= cfg_data;
				REG_REFLECT_INPUT:  reflect_input_q  <= cfg_data[0];
				REG_REFLECT_OUTPUT: reflect_output_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		back_cfg.width_select   = width_select_q;
		back_cfg.polynomial     = polynomial_q;
		back_cfg.init_value     = init_value_q;
		back_cfg.final_xor      = final_xor_q;
		back_cfg.reflect_output = reflect_output_q;
	end

	ccrc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.has_data      (has_data),
		.last_byte     (last_byte),
		.reflect_input (reflect_input_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	ccrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.crc_value (crc_value)
	);

endmodule
